/* design/config_frame_deframer_macros.svh */
// Assertion macros used by the deframer parser (cfd_parser).
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CONFIG_FRAME_DEFRAMER_MACROS_SVH
`define CONFIG_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

/* design/cfd_pkg.sv */
// Package for the configuration frame deframer: phase type, result type and constants.
// Used by cfd_parser and config_frame_deframer; depends on nothing else.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam logic [7:0] SYNC_BYTE_RESET = 8'hA5;

    localparam logic [2:0] HDR_POS_NUMBER = 3'd2;
    localparam logic [2:0] HDR_POS_LEN_LO = 3'd3;
    localparam logic [2:0] HDR_POS_LEN_HI = 3'd4;

    localparam logic [15:0] TYP_POS_TYPE    = 16'd1;
    localparam logic [15:0] TYP_POS_STATUS  = 16'd2;
    localparam logic [15:0] TYP_POS_SIZE_LO = 16'd3;
    localparam logic [15:0] TYP_POS_SIZE_HI = 16'd4;
    localparam logic [15:0] TYP_HDR_BYTES   = 16'd4;
    localparam logic [15:0] PAYLOAD_BASE    = 16'd5;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_DATA,
        PH_CHECK
    } cfd_phase_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] offset;
        logic [7:0]  block_type;
        logic [7:0]  block_status;
        logic [7:0]  block_number;
        logic [15:0] block_size;
    } cfd_result_t;

endpackage

/* design/config_frame_deframer.sv */
// Configuration frame deframer, top level: input register, parser and result register.
// Path: a byte accepted into the input register passes through the parser into the result register, then to m_*.
// Throughput: one byte per cycle while m_tready does not stall the result register; s_tready follows m_tready.
// Reset: aresetn is synchronous, active low; it empties both registers, sets hunting
// for sync and loads the sync byte register with 0xA5. Depends on cfd_pkg and cfd_parser.
`timescale 1ns / 1ps

module config_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte[7:0], offset[23:8], block_type[31:24], block_status[39:32],
    // block_number[47:40], block_size[63:48]
    output logic [63:0] m_tdata,
    output logic        m_tlast    // kind: high on the frame-complete item
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    cfd_pkg::cfd_result_t out_reg;
    cfd_pkg::cfd_result_t result;
    logic                 advance;
    logic                 step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    cfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .in_byte   (in_byte_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.kind;
    assign m_tdata  = {out_reg.block_size, out_reg.block_number, out_reg.block_status,
                       out_reg.block_type, out_reg.offset, out_reg.data_byte};

endmodule

/* design/cfd_parser.sv */
// Frame parser: sync register, phase state machine and header fields.
// Takes one byte per step and produces at most one result; depends on cfd_pkg.
`timescale 1ns / 1ps
`include "config_frame_deframer_macros.svh"

module cfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output cfd_pkg::cfd_result_t result
);

    logic [7:0]          sync_byte_reg;
    cfd_pkg::cfd_phase_t phase_reg, phase_next;
    logic [2:0]          header_count_reg, header_count_next;
    logic [15:0]         data_count_reg, data_count_next;
    logic [15:0]         frame_length_reg, frame_length_next;
    logic [7:0]          frame_block_reg, frame_block_next;
    logic [7:0]          type_value_reg, type_value_next;
    logic [7:0]          status_value_reg, status_value_next;
    logic [15:0]         size_value_reg, size_value_next;

    logic [2:0]  hc_inc;
    logic [15:0] dc_inc;
    logic [15:0] length_full;
    logic [15:0] size_full;
    logic [16:0] size_plus;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= cfd_pkg::SYNC_BYTE_RESET;
        end else if (cfg_we) begin
            sync_byte_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= cfd_pkg::PH_HUNT;
            header_count_reg <= '0;
            data_count_reg   <= '0;
            frame_length_reg <= '0;
            frame_block_reg  <= '0;
            type_value_reg   <= '0;
            status_value_reg <= '0;
            size_value_reg   <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            data_count_reg   <= data_count_next;
            frame_length_reg <= frame_length_next;
            frame_block_reg  <= frame_block_next;
            type_value_reg   <= type_value_next;
            status_value_reg <= status_value_next;
            size_value_reg   <= size_value_next;
        end
    end

    always_comb begin
        hc_inc      = header_count_reg + 3'd1;
        dc_inc      = data_count_reg + 16'd1;
        length_full = {in_byte, frame_length_reg[7:0]};
        size_full   = {in_byte, size_value_reg[7:0]};
        size_plus   = {1'b0, size_full} + {1'b0, cfd_pkg::TYP_HDR_BYTES};

        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        data_count_next   = data_count_reg;
        frame_length_next = frame_length_reg;
        frame_block_next  = frame_block_reg;
        type_value_next   = type_value_reg;
        status_value_next = status_value_reg;
        size_value_next   = size_value_reg;

        result.valid        = 1'b0;
        result.kind         = cfd_pkg::KIND_PAYLOAD;
        result.data_byte    = in_byte;
        result.offset       = '0;
        result.block_type   = type_value_reg;
        result.block_status = status_value_reg;
        result.block_number = frame_block_reg;
        result.block_size   = size_value_reg;

        case (phase_reg)
            cfd_pkg::PH_HUNT: begin
                if (in_byte == sync_byte_reg) begin
                    phase_next        = cfd_pkg::PH_HEAD;
                    header_count_next = 3'd1;
                    data_count_next   = '0;
                    frame_length_next = '0;
                    type_value_next   = '0;
                    status_value_next = '0;
                    size_value_next   = '0;
                end
            end
            cfd_pkg::PH_HEAD: begin
                header_count_next = hc_inc;
                if (hc_inc == cfd_pkg::HDR_POS_NUMBER) begin
                    frame_block_next = in_byte;
                end else if (hc_inc == cfd_pkg::HDR_POS_LEN_LO) begin
                    frame_length_next = {8'd0, in_byte};
                end else if (hc_inc == cfd_pkg::HDR_POS_LEN_HI) begin
                    frame_length_next = length_full;
                    phase_next = (length_full != 16'd0) ? cfd_pkg::PH_DATA : cfd_pkg::PH_CHECK;
                end
            end
            cfd_pkg::PH_DATA: begin
                data_count_next = dc_inc;
                if (dc_inc == cfd_pkg::TYP_POS_TYPE) begin
                    type_value_next = in_byte;
                    size_value_next = '0;
                end else if (dc_inc == cfd_pkg::TYP_POS_STATUS) begin
                    status_value_next = in_byte;
                end else if (dc_inc == cfd_pkg::TYP_POS_SIZE_LO) begin
                    size_value_next = {8'd0, in_byte};
                end else if (dc_inc == cfd_pkg::TYP_POS_SIZE_HI) begin
                    size_value_next = size_full;
                    if (size_plus != {1'b0, frame_length_reg}) begin
                        phase_next = cfd_pkg::PH_HUNT;
                    end else if (size_full == 16'd0) begin
                        phase_next = cfd_pkg::PH_CHECK;
                    end
                end else if (dc_inc > frame_length_reg) begin
                    phase_next = cfd_pkg::PH_CHECK;
                end else begin
                    result.valid  = 1'b1;
                    result.offset = dc_inc - cfd_pkg::PAYLOAD_BASE;
                    if (dc_inc >= frame_length_reg) begin
                        phase_next = cfd_pkg::PH_CHECK;
                    end
                end
            end
            cfd_pkg::PH_CHECK: begin
                phase_next   = cfd_pkg::PH_HUNT;
                result.valid = 1'b1;
                result.kind  = cfd_pkg::KIND_COMPLETE;
            end
            default: begin
                phase_next = cfd_pkg::PH_HUNT;
            end
        endcase

        result.valid = result.valid & step;
    end

    // A checksum byte always returns the parser to hunting.
    `CFD_ASSERT_NEXT(a_check_to_hunt, step && phase_reg == cfd_pkg::PH_CHECK, phase_reg == cfd_pkg::PH_HUNT)
    // No result is produced while hunting or collecting the frame header.
    `CFD_ASSERT_SAME(a_no_result_early, phase_reg == cfd_pkg::PH_HUNT || phase_reg == cfd_pkg::PH_HEAD, !result.valid)
    // Payload items come only from the data phase.
    `CFD_ASSERT_SAME(a_payload_in_data, result.valid && result.kind == cfd_pkg::KIND_PAYLOAD, phase_reg == cfd_pkg::PH_DATA)
    // Once the type header is in, the data counter stays below the frame length.
    `CFD_ASSERT_SAME(a_count_in_frame, phase_reg == cfd_pkg::PH_DATA && data_count_reg >= cfd_pkg::TYP_HDR_BYTES, data_count_reg < frame_length_reg)

endmodule
